/* src/bubble_sort_ascending_unit_assert.svh */
// assertion macros for the sorter, sampled on clk and disabled in reset
`ifndef BUBBLE_SORT_ASCENDING_UNIT_ASSERT_SVH
`define BUBBLE_SORT_ASCENDING_UNIT_ASSERT_SVH

`ifndef SYNTH

`define BSAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsau assertion failed");

`define BSAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsau sequence assertion failed");

`else

`define BSAU_ASSERT(lbl, prop)
`define BSAU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/bsau_pkg.sv */
package bsau_pkg;

  localparam int VALUE_W       = 32;
  localparam int DEPTH_DEFAULT = 16;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic ins;
    logic shift_out;
  } ctrl_t;

endpackage

/* src/bsau_if.sv */
interface bsau_in_if;
  logic                  valid;
  logic                  ready;
  bsau_pkg::value_t      sample_value;
  logic                  is_final;

  modport source (output valid, output sample_value, output is_final, input ready);
  modport sink   (input valid, input sample_value, input is_final, output ready);
endinterface

interface bsau_out_if;
  logic                  valid;
  logic                  ready;
  bsau_pkg::value_t      sorted_value;
  logic                  last_of_run;

  modport source (output valid, output sorted_value, output last_of_run, input ready);
  modport sink   (input valid, input sorted_value, input last_of_run, output ready);
endinterface

/* src/bubble_sort_ascending_unit.sv */
// Stable ascending sorter for sets of up to DEPTH signed 32-bit words. Words of a set are
// taken one per cycle; each is inserted in place into a chain of DEPTH compare cells, which
// keeps the stored words ordered at all times. Words that arrive while DEPTH are stored are
// dropped, but a final mark on a dropped word still closes the set. After the final word the
// input is held off and the sorted words leave from the head of the chain, one per cycle
// while the sink is ready, the greatest one marked last_of_run; then the input opens for the
// next set.
module bubble_sort_ascending_unit #(
  parameter int DEPTH = bsau_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  bsau_in_if.sink     in_ch,
  bsau_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  bsau_pkg::state_t state_r;
  bsau_pkg::state_t state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  bsau_pkg::ctrl_t  ctrl;
  logic             in_fire;
  logic             out_fire;
  logic             room;

  logic             takes [DEPTH];
  bsau_pkg::value_t vals  [DEPTH];

  assign room     = (cnt_r < CNT_W'(DEPTH));
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  assign ctrl.ins       = in_fire && room;
  assign ctrl.shift_out = out_fire;

  assign out_ch.sorted_value = vals[0];
  assign out_ch.last_of_run  = (cnt_r == CNT_W'(1));

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      bsau_pkg::ST_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_fire && room) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (in_fire && in_ch.is_final) begin
          state_nxt = bsau_pkg::ST_DRAIN;
        end
      end
      bsau_pkg::ST_DRAIN: begin
        out_ch.valid = 1'b1;
        if (out_fire) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = bsau_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = bsau_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsau_pkg::ST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             left_take;
    bsau_pkg::value_t left_value;
    bsau_pkg::value_t right_value;

    if (i == 0) begin : g_head
      assign left_take  = 1'b0;
      assign left_value = in_ch.sample_value;
    end else begin : g_body
      assign left_take  = takes[i-1];
      assign left_value = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = vals[i];
    end else begin : g_mid
      assign right_value = vals[i+1];
    end

    bsau_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_value   (in_ch.sample_value),
      .occupied    (cnt_r > CNT_W'(i)),
      .left_take   (left_take),
      .left_value  (left_value),
      .right_value (right_value),
      .take        (takes[i]),
      .value       (vals[i])
    );
  end

`include "bubble_sort_ascending_unit_assert.svh"

  `BSAU_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(DEPTH))
  `BSAU_ASSERT(a_drain_nonempty, (state_r == bsau_pkg::ST_DRAIN) |-> (cnt_r != '0))
  `BSAU_ASSERT(a_no_overlap, !(in_ch.ready && out_ch.valid))
  `BSAU_ASSERT_NEXT(a_run_ends, out_fire && out_ch.last_of_run, state_r == bsau_pkg::ST_LOAD && cnt_r == '0)
  `BSAU_ASSERT_NEXT(a_ascending, out_fire && !out_ch.last_of_run, out_ch.sorted_value >= $past(out_ch.sorted_value))

endmodule

/* src/bsau_cell.sv */
module bsau_cell (
  input  logic              clk,
  input  bsau_pkg::ctrl_t   ctrl,
  input  bsau_pkg::value_t  new_value,
  input  logic              occupied,
  input  logic              left_take,
  input  bsau_pkg::value_t  left_value,
  input  bsau_pkg::value_t  right_value,
  output logic              take,
  output bsau_pkg::value_t  value
);

  bsau_pkg::value_t val_r;
  bsau_pkg::value_t val_nxt;

  // ties go behind the stored word, keeping arrival order
  assign take  = !occupied || (new_value < val_r);
  assign value = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins && take) begin
      val_nxt = left_take ? left_value : new_value;
    end else if (ctrl.shift_out) begin
      val_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SORT_DEPTH = bsau_pkg::DEPTH_DEFAULT;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    bsau_pkg::value_t sample_value;
    logic             is_final;
  } feed_word_t;

  typedef struct {
    bsau_pkg::value_t sorted_value;
    logic             last_of_run;
  } sorted_word_t;

  typedef enum int {
    MODE_STEADY,
    MODE_SRC_GAPS,
    MODE_SNK_STALLS,
    MODE_BOTH
  } idle_mode_e;

  logic clk;
  logic rst_n;

  bsau_in_if  in_ch ();
  bsau_out_if out_ch ();

  bubble_sort_ascending_unit #(
    .DEPTH(SORT_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  feed_word_t       feed_queue[$];
  sorted_word_t     sorted_due[$];
  bsau_pkg::value_t held_words[$];
  idle_mode_e       idle_mode;
  logic             hold_go;
  logic             hold_seen;
  int               hold_left;
  int               fail_count;
  int               words_in;
  int               words_out;
  int               sets_sorted;
  int               overrun_sets;
  bit               overrun_now;

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  function automatic bit sender_idles();
    case (idle_mode)
      MODE_SRC_GAPS: return $urandom_range(0, 99) < 87;
      MODE_BOTH:     return $urandom_range(0, 99) < 7;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      MODE_SNK_STALLS: return $urandom_range(0, 99) < 87;
      MODE_BOTH:       return $urandom_range(0, 99) < 7;
      default:         return 1'b0;
    endcase
  endfunction

  // store the word; on the final mark sort what was kept and queue the run
  function automatic void absorb_word(bsau_pkg::value_t sample, logic fin);
    bsau_pkg::value_t swap;
    int               n;
    words_in++;
    if (held_words.size() < SORT_DEPTH) begin
      held_words.push_back(sample);
    end else begin
      overrun_now = 1'b1;
    end
    if (fin) begin
      n = held_words.size();
      for (int pass = 0; pass < n; pass++) begin
        for (int k = 0; k + 1 < n; k++) begin
          if (held_words[k] > held_words[k+1]) begin
            swap = held_words[k];
            held_words[k] = held_words[k+1];
            held_words[k+1] = swap;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        sorted_due.push_back('{held_words[k], (k == n - 1)});
      end
      held_words.delete();
      sets_sorted++;
      if (overrun_now) begin
        overrun_sets++;
      end
      overrun_now = 1'b0;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    feed_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (feed_queue.size() > 0 && !sender_idles()) begin
        w = feed_queue.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= w.sample_value;
        in_ch.is_final     <= w.is_final;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= hold_go;
      hold_left    <= 0;
    end else if (hold_go != hold_seen) begin
      hold_seen    <= hold_go;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !receiver_stalls();
    end
  end

  // monitor
  always @(posedge clk) begin
    sorted_word_t exp_w;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_word(in_ch.sample_value, in_ch.is_final);
      end
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (sorted_due.size() == 0) begin
          $error("unexpected word: sorted_value %0d last_of_run %0b",
                 out_ch.sorted_value, out_ch.last_of_run);
          fail_count++;
        end else begin
          exp_w = sorted_due.pop_front();
          if (out_ch.sorted_value !== exp_w.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d",
                   exp_w.sorted_value, out_ch.sorted_value);
            fail_count++;
          end
          if (out_ch.last_of_run !== exp_w.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b",
                   exp_w.last_of_run, out_ch.last_of_run);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic bsau_pkg::value_t pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return '0;
          default: return -1;
        endcase
      end
      1, 2, 3: return bsau_pkg::value_t'($urandom_range(0, 6)) - 3;
      default: return bsau_pkg::value_t'($urandom());
    endcase
  endfunction

  task automatic queue_set(int len);
    for (int i = 0; i < len; i++) begin
      feed_queue.push_back('{pick_value(), (i == len - 1)});
    end
  endtask

  task automatic queue_random_sets(int budget);
    int queued;
    int len;
    queued = 0;
    while (queued < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 4)
                                        : $urandom_range(1, SORT_DEPTH);
      queue_set(len);
      queued += len;
    end
  endtask

  task automatic wait_drained();
    while (feed_queue.size() > 0 || in_ch.valid) begin
      @(posedge clk);
    end
    while (sorted_due.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    hold_go            = 1'b0;
    idle_mode          = MODE_STEADY;
    in_ch.valid        = 1'b0;
    in_ch.sample_value = '0;
    in_ch.is_final     = 1'b0;
    out_ch.ready       = 1'b0;
    fail_count         = 0;
    words_in           = 0;
    words_out          = 0;
    sets_sorted        = 0;
    overrun_sets       = 0;
    overrun_now        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // single word, extremes with repeats, and an overlong descending set
    feed_queue.push_back('{32'sh7fffffff, 1'b1});
    feed_queue.push_back('{32'sh7fffffff, 1'b0});
    feed_queue.push_back('{32'sh80000000, 1'b0});
    feed_queue.push_back('{-1, 1'b0});
    feed_queue.push_back('{'0, 1'b0});
    feed_queue.push_back('{32'sh80000000, 1'b0});
    feed_queue.push_back('{32'sh7fffffff, 1'b1});
    for (int i = 0; i < SORT_DEPTH + 2; i++) begin
      feed_queue.push_back('{bsau_pkg::value_t'(1000 - 300 * i), (i == SORT_DEPTH + 1)});
    end
    wait_drained();

    // receiver held off while sets of 12, SORT_DEPTH and 10 words are queued
    @(posedge clk);
    hold_go <= ~hold_go;
    queue_set(12);
    queue_set(SORT_DEPTH);
    queue_set(10);
    wait_drained();

    for (int m = MODE_STEADY; m <= MODE_BOTH; m++) begin
      @(posedge clk);
      idle_mode <= idle_mode_e'(m);
      queue_random_sets(33);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (sorted_due.size() != 0) begin
      $error("%0d sorted words never arrived", sorted_due.size());
      fail_count++;
    end
    $display("%0d sets sorted from %0d words, %0d words returned", sets_sorted, words_in,
             words_out);
    $display("%0d sets overran the %0d-entry store; idle, stall and hold-off phases run",
             overrun_sets, SORT_DEPTH);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/bsau_pkg.sv
src/bsau_if.sv
src/bsau_cell.sv
src/bubble_sort_ascending_unit.sv
verif/tb.sv
